// ===== sv/tvas_pkg.sv =====
// Package for the one-voice tone generator: types, codes, constants and the
// quarter-wave sine table built at elaboration. No dependencies.
package tvas_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);
	localparam int SINE_QTR = SINE_TABLE_DEPTH / 4;
	localparam int SINE_IDX_W = $clog2(SINE_QTR) + 1;
	localparam int SINE_SHIFT = 32 - SINE_BITS;
	localparam int FRAME_BITS = 24;
	localparam int PHASE_BITS = 32;

	localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] PCG_INC = 64'd1442695040888963407;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [16:0] Q16_ONE = 17'h10000;
	localparam logic [15:0] PCM_MAX = 16'd32767;

	localparam int MUL_W = 64;
	localparam int NUM_W = 48;
	localparam int DSR_W = 26;

	typedef enum logic [2:0] {
		WAVE_SINE = 3'd0,
		WAVE_SQUARE = 3'd1,
		WAVE_SAW = 3'd2,
		WAVE_TRI = 3'd3,
		WAVE_NOISE = 3'd4
	} wave_t;

	typedef enum logic [2:0] {
		REG_WAVEFORM = 3'd0,
		REG_DUTY = 3'd1,
		REG_AMPLITUDE = 3'd2,
		REG_SUSTAIN = 3'd3,
		REG_ATTACK = 3'd4,
		REG_DECAY = 3'd5,
		REG_RELEASE = 3'd6
	} cfg_reg_t;

	localparam logic REQ_START = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP_DIV,
		ST_SCALE_CHK,
		ST_SCALE_MUL,
		ST_SCALE_DIV,
		ST_SEED_MUL,
		ST_NOISE_MUL,
		ST_ENV_SEL,
		ST_ENV_MUL,
		ST_ENV_DIV,
		ST_AMP_MUL1,
		ST_AMP_MUL2,
		ST_AMP_MUL3,
		ST_FINISH
	} st_t;

	typedef logic [SINE_QTR:0][16:0] sine_rom_t;

	function automatic logic [16:0] clamp_one(input logic [16:0] x);
		clamp_one = (x > Q16_ONE) ? Q16_ONE : x;
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] r, a, a2, term, sum, s16;
		int j, n;
		rom = '0;
		for (j = 0; j <= SINE_QTR; j++) begin
			r = 64'(j) << SINE_SHIFT;
			a = (r * HALF_PI_Q30) >> 30;
			a2 = (a * a) >> 30;
			term = a;
			sum = a;
			for (n = 1; n <= 6; n++) begin
				term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			s16 = (sum + 64'd8192) >> 14;
			if (s16 > 64'(Q16_ONE)) s16 = 64'(Q16_ONE);
			rom[j] = s16[16:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

endpackage

// ===== sv/tvas_mul.sv =====
// Bit-serial shift-add multiplier, low 64 bits of the product.
// Depends on tvas_pkg for the operand width.
module tvas_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [tvas_pkg::MUL_W-1:0] a,
	input  logic [tvas_pkg::MUL_W-1:0] b,
	output logic done,
	output logic [tvas_pkg::MUL_W-1:0] p
);
	logic [tvas_pkg::MUL_W-1:0] a_q, b_q, p_q;
	logic busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= {a_q[tvas_pkg::MUL_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[tvas_pkg::MUL_W-1:1]};
		end
	end

	assign done = done_q;
	assign p = p_q;
endmodule

// ===== sv/tvas_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on tvas_pkg for dividend and divisor widths.
module tvas_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [tvas_pkg::NUM_W-1:0] num,
	input  logic [tvas_pkg::DSR_W-1:0] dsr,
	output logic done,
	output logic [tvas_pkg::NUM_W-1:0] q
);
	localparam int CNT_W = $clog2(tvas_pkg::NUM_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tvas_pkg::NUM_W - 1);

	logic [tvas_pkg::NUM_W-1:0] dvd_q;
	logic [tvas_pkg::DSR_W-1:0] dsr_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [tvas_pkg::DSR_W:0] trial;
	logic fits;

	assign trial = {rem_q, dvd_q[tvas_pkg::NUM_W-1]};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num;
			dsr_q <= dsr;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? tvas_pkg::DSR_W'(trial - {1'b0, dsr_q})
			              : trial[tvas_pkg::DSR_W-1:0];
			dvd_q <= {dvd_q[tvas_pkg::NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign q = dvd_q;
endmodule

// ===== sv/tvas_wave.sv =====
// Waveform value from phase and noise state, as sign and Q.16 magnitude.
// Depends on tvas_pkg for the sine table, codes and constants.
module tvas_wave (
	input  logic [2:0] waveform,
	input  logic [16:0] duty,
	input  logic [31:0] phase,
	input  logic [63:0] noise_state,
	output logic neg,
	output logic [16:0] mag
);
	logic [tvas_pkg::SINE_BITS-1:0] k;
	logic [tvas_pkg::SINE_IDX_W-1:0] low, ridx;
	logic [16:0] s;
	logic [31:0] xs, x;
	logic [4:0] rot;
	logic signed [18:0] v;

	assign k = phase[31 -: tvas_pkg::SINE_BITS];
	assign low = tvas_pkg::SINE_IDX_W'(k[tvas_pkg::SINE_BITS-3:0]);
	assign ridx = k[tvas_pkg::SINE_BITS-2] ? tvas_pkg::SINE_IDX_W'(tvas_pkg::SINE_QTR) - low : low;
	assign s = tvas_pkg::SINE_ROM[ridx];

	assign xs = 32'(((noise_state >> 18) ^ noise_state) >> 27);
	assign rot = noise_state[63:59];
	assign x = (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));

	always_comb begin
		case (waveform)
			tvas_pkg::WAVE_SINE:
				v = k[tvas_pkg::SINE_BITS-1] ? -$signed({2'b00, s}) : $signed({2'b00, s});
			tvas_pkg::WAVE_SQUARE:
				v = ({1'b0, phase} < {tvas_pkg::clamp_one(duty), 16'h0000}) ? 19'sd65536
				                                                              : -19'sd65536;
			tvas_pkg::WAVE_SAW:
				v = $signed({2'b00, phase[31:15]}) - 19'sd65536;
			tvas_pkg::WAVE_TRI:
				v = !phase[31] ? $signed({1'b0, phase[31:14]}) - 19'sd65536
				               : 19'sd196608 - $signed({1'b0, phase[31:14]});
			tvas_pkg::WAVE_NOISE:
				v = $signed({2'b00, x[31:15]}) - 19'sd65536;
			default:
				v = '0;
		endcase
	end

	assign neg = v[18];
	assign mag = v[18] ? 17'(-v) : v[16:0];
endmodule

// ===== sv/tone_voice_adsr_sweep.sv =====
// A start runs a step division for notes longer than one frame, then, if attack, decay
// and release together exceed the note, three scalings of a multiply and a divide each,
// then a seed multiply. An active tick runs a noise multiply for noise, the envelope
// steps and three amplitude multiplies, and it waits until the previous word leaves.
// One item is in work at a time; the rate is set by the shared bit-serial multiplier and
// divider. An idle tick is taken and gives no word. Asynchronous active-low reset loads
// the default registers and leaves the voice idle.
module tone_voice_adsr_sweep (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [23:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic [23:0] note_frames,
	input  logic [63:0] noise_seed,
	input  logic [31:0] start_step,
	input  logic [31:0] end_step,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [15:0] sample,
	output logic last_sample
);
	tvas_pkg::st_t state_q, state_nx;

	logic [2:0] waveform_q;
	logic [16:0] duty_q, amp_q, sus_q;
	logic [23:0] att_q, dec_q, rel_q;

	logic [31:0] phase_q;
	logic [47:0] step_acc_q, step_delta_q;
	logic [23:0] frame_q, len_q, sc_att_q, sc_dec_q, sc_rel_q;
	logic [63:0] noise_q;
	logic active_q;

	logic [31:0] dmag_q;
	logic down_q;
	logic [1:0] sc_idx_q;
	logic sign_q;
	logic [16:0] mag_q, env_q;
	logic [40:0] env_num_q;
	logic [23:0] env_dsr_q;
	logic env_sub_q;
	logic launch_q;
	logic signed [15:0] sample_q;
	logic last_q, out_valid_q;

	logic in_acc, out_slot;
	logic mul_start, mul_done, div_start, div_done;
	logic [63:0] mul_a, mul_b, mul_p;
	logic [47:0] div_num, div_q;
	logic [25:0] div_dsr, adr_sum;
	logic wneg;
	logic [16:0] wmag, sus_c;
	logic env_att, env_dec, env_rel;
	logic [23:0] sc_raw, frame_nx;
	logic [63:0] rsum;
	logic [15:0] qmag;

	assign in_acc = in_valid && in_ready;
	assign out_slot = !out_valid_q || out_ready;
	assign adr_sum = 26'(att_q) + 26'(dec_q) + 26'(rel_q);
	assign sus_c = tvas_pkg::clamp_one(sus_q);
	assign env_att = frame_q < sc_att_q;
	assign env_dec = {1'b0, frame_q} < (25'(sc_att_q) + 25'(sc_dec_q));
	assign env_rel = !((25'(frame_q) + 25'(sc_rel_q)) < {1'b0, len_q}) && (sc_rel_q != '0);
	assign frame_nx = frame_q + 24'd1;
	assign rsum = mul_p + 64'h0000_8000_0000_0000;
	assign qmag = (rsum[63:48] > tvas_pkg::PCM_MAX) ? tvas_pkg::PCM_MAX : rsum[63:48];

	always_comb begin
		case (sc_idx_q)
			2'd0: sc_raw = att_q;
			2'd1: sc_raw = dec_q;
			default: sc_raw = rel_q;
		endcase
	end

	tvas_wave u_wave (
		.waveform(waveform_q),
		.duty(duty_q),
		.phase(phase_q),
		.noise_state(noise_q),
		.neg(wneg),
		.mag(wmag)
	);

	tvas_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.p(mul_p)
	);

	tvas_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.dsr(div_dsr),
		.done(div_done),
		.q(div_q)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tvas_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (req_type == tvas_pkg::REQ_START)
						state_nx = (note_frames > 24'd1) ? tvas_pkg::ST_STEP_DIV
						                                 : tvas_pkg::ST_SCALE_CHK;
					else if (active_q)
						state_nx = (waveform_q == tvas_pkg::WAVE_NOISE) ? tvas_pkg::ST_NOISE_MUL
						                                                : tvas_pkg::ST_ENV_SEL;
				end
			end
			tvas_pkg::ST_STEP_DIV: if (div_done) state_nx = tvas_pkg::ST_SCALE_CHK;
			tvas_pkg::ST_SCALE_CHK:
				state_nx = (adr_sum > 26'(len_q)) ? tvas_pkg::ST_SCALE_MUL : tvas_pkg::ST_SEED_MUL;
			tvas_pkg::ST_SCALE_MUL: if (mul_done) state_nx = tvas_pkg::ST_SCALE_DIV;
			tvas_pkg::ST_SCALE_DIV: begin
				if (div_done)
					state_nx = (sc_idx_q == 2'd2) ? tvas_pkg::ST_SEED_MUL : tvas_pkg::ST_SCALE_MUL;
			end
			tvas_pkg::ST_SEED_MUL: if (mul_done) state_nx = tvas_pkg::ST_IDLE;
			tvas_pkg::ST_NOISE_MUL: if (mul_done) state_nx = tvas_pkg::ST_ENV_SEL;
			tvas_pkg::ST_ENV_SEL: begin
				if (env_att) state_nx = tvas_pkg::ST_ENV_DIV;
				else if (env_dec || env_rel) state_nx = tvas_pkg::ST_ENV_MUL;
				else state_nx = tvas_pkg::ST_AMP_MUL1;
			end
			tvas_pkg::ST_ENV_MUL: if (mul_done) state_nx = tvas_pkg::ST_ENV_DIV;
			tvas_pkg::ST_ENV_DIV: if (div_done) state_nx = tvas_pkg::ST_AMP_MUL1;
			tvas_pkg::ST_AMP_MUL1: if (mul_done) state_nx = tvas_pkg::ST_AMP_MUL2;
			tvas_pkg::ST_AMP_MUL2: if (mul_done) state_nx = tvas_pkg::ST_AMP_MUL3;
			tvas_pkg::ST_AMP_MUL3: if (mul_done) state_nx = tvas_pkg::ST_FINISH;
			tvas_pkg::ST_FINISH: if (out_slot) state_nx = tvas_pkg::ST_IDLE;
			default: state_nx = tvas_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_num = '0;
		div_dsr = '0;
		unique case (state_q)
			tvas_pkg::ST_IDLE: in_ready = 1'b1;
			tvas_pkg::ST_STEP_DIV: begin
				div_start = !launch_q;
				div_num = {dmag_q, 16'h0000};
				div_dsr = 26'(len_q - 24'd1);
			end
			tvas_pkg::ST_SCALE_MUL: begin
				mul_start = !launch_q;
				mul_a = 64'(sc_raw);
				mul_b = 64'(len_q);
			end
			tvas_pkg::ST_SCALE_DIV: begin
				div_start = !launch_q;
				div_num = mul_p[47:0];
				div_dsr = adr_sum;
			end
			tvas_pkg::ST_SEED_MUL, tvas_pkg::ST_NOISE_MUL: begin
				mul_start = !launch_q;
				mul_a = noise_q;
				mul_b = tvas_pkg::PCG_MUL;
			end
			tvas_pkg::ST_ENV_MUL: begin
				mul_start = !launch_q;
				mul_a = env_sub_q ? 64'(tvas_pkg::Q16_ONE - sus_c) : 64'(sus_c);
				mul_b = env_sub_q ? 64'(frame_q - sc_att_q) : 64'(len_q - frame_q);
			end
			tvas_pkg::ST_ENV_DIV: begin
				div_start = !launch_q;
				div_num = 48'(env_num_q);
				div_dsr = 26'(env_dsr_q);
			end
			tvas_pkg::ST_AMP_MUL1: begin
				mul_start = !launch_q;
				mul_a = 64'(mag_q);
				mul_b = 64'(env_q);
			end
			tvas_pkg::ST_AMP_MUL2: begin
				mul_start = !launch_q;
				mul_a = mul_p;
				mul_b = 64'(tvas_pkg::clamp_one(amp_q));
			end
			tvas_pkg::ST_AMP_MUL3: begin
				mul_start = !launch_q;
				mul_a = mul_p;
				mul_b = 64'(tvas_pkg::PCM_MAX);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvas_pkg::ST_IDLE;
			launch_q <= 1'b0;
			out_valid_q <= 1'b0;
			active_q <= 1'b0;
			waveform_q <= tvas_pkg::WAVE_SINE;
			duty_q <= 17'd32768;
			amp_q <= tvas_pkg::Q16_ONE;
			sus_q <= tvas_pkg::Q16_ONE;
			att_q <= '0;
			dec_q <= '0;
			rel_q <= '0;
			phase_q <= '0;
			step_acc_q <= '0;
			step_delta_q <= '0;
			frame_q <= '0;
			len_q <= '0;
			sc_att_q <= '0;
			sc_dec_q <= '0;
			sc_rel_q <= '0;
			noise_q <= '0;
			sc_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (mul_start || div_start) launch_q <= 1'b1;
			else if (mul_done || div_done) launch_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					tvas_pkg::REG_WAVEFORM: waveform_q <= cfg_data[2:0];
					tvas_pkg::REG_DUTY: duty_q <= cfg_data[16:0];
					tvas_pkg::REG_AMPLITUDE: amp_q <= cfg_data[16:0];
					tvas_pkg::REG_SUSTAIN: sus_q <= cfg_data[16:0];
					tvas_pkg::REG_ATTACK: att_q <= cfg_data;
					tvas_pkg::REG_DECAY: dec_q <= cfg_data;
					tvas_pkg::REG_RELEASE: rel_q <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == tvas_pkg::ST_FINISH && out_slot) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			case (state_q)
				tvas_pkg::ST_IDLE: begin
					if (in_acc && req_type == tvas_pkg::REQ_START) begin
						len_q <= note_frames;
						frame_q <= '0;
						phase_q <= '0;
						step_acc_q <= {start_step, 16'h0000};
						step_delta_q <= '0;
						noise_q <= noise_seed + tvas_pkg::PCG_INC;
						active_q <= 1'b0;
						sc_idx_q <= '0;
					end
				end
				tvas_pkg::ST_STEP_DIV: begin
					if (div_done) step_delta_q <= down_q ? 48'(-div_q) : div_q;
				end
				tvas_pkg::ST_SCALE_CHK: begin
					if (!(adr_sum > 26'(len_q))) begin
						sc_att_q <= att_q;
						sc_dec_q <= dec_q;
						sc_rel_q <= rel_q;
					end
				end
				tvas_pkg::ST_SCALE_DIV: begin
					if (div_done) begin
						case (sc_idx_q)
							2'd0: sc_att_q <= div_q[23:0];
							2'd1: sc_dec_q <= div_q[23:0];
							default: sc_rel_q <= div_q[23:0];
						endcase
						sc_idx_q <= sc_idx_q + 2'd1;
					end
				end
				tvas_pkg::ST_SEED_MUL: begin
					if (mul_done) begin
						noise_q <= mul_p + tvas_pkg::PCG_INC;
						active_q <= len_q != '0;
					end
				end
				tvas_pkg::ST_NOISE_MUL: begin
					if (mul_done) noise_q <= mul_p + tvas_pkg::PCG_INC;
				end
				tvas_pkg::ST_FINISH: begin
					if (out_slot) begin
						phase_q <= phase_q + step_acc_q[47:16];
						step_acc_q <= step_acc_q + step_delta_q;
						frame_q <= frame_nx;
						if (frame_nx == len_q || frame_nx == '0) active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tvas_pkg::ST_IDLE: begin
				if (in_acc) begin
					dmag_q <= (end_step >= start_step) ? end_step - start_step
					                                   : start_step - end_step;
					down_q <= end_step < start_step;
					sign_q <= wneg;
					mag_q <= wmag;
				end
			end
			tvas_pkg::ST_ENV_SEL: begin
				if (env_att) begin
					env_num_q <= 41'({frame_q, 16'h0000});
					env_dsr_q <= sc_att_q;
					env_sub_q <= 1'b0;
				end else if (env_dec) begin
					env_dsr_q <= sc_dec_q;
					env_sub_q <= 1'b1;
				end else if (env_rel) begin
					env_dsr_q <= sc_rel_q;
					env_sub_q <= 1'b0;
				end else begin
					env_q <= sus_c;
				end
			end
			tvas_pkg::ST_ENV_MUL: begin
				if (mul_done) env_num_q <= mul_p[40:0];
			end
			tvas_pkg::ST_ENV_DIV: begin
				if (div_done) env_q <= env_sub_q ? tvas_pkg::Q16_ONE - div_q[16:0] : div_q[16:0];
			end
			tvas_pkg::ST_FINISH: begin
				if (out_slot) begin
					sample_q <= sign_q ? -$signed(qmag) : $signed(qmag);
					last_q <= frame_nx == len_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign last_sample = last_q;
endmodule

// ===== sv/tvas_chk.sv =====
// Port-level checker for the tone generator and its bind to the top level.
// Depends only on the ports of tone_voice_adsr_sweep.
module tvas_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic req_type,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] sample,
	input logic last_sample
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last_sample))
		else $error("output word changed while stalled");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == 1'b0 |=> !in_ready && !$rose(out_valid))
		else $error("start word did not occupy the voice");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 16'sh8000)
		else $error("sample outside the symmetric range");

	a_word_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("word appeared without work in progress");
endmodule

bind tone_voice_adsr_sweep tvas_chk u_tvas_chk (.*);
